@@ rtl/mbss_pkg.sv @@
`timescale 1ns / 1ps

package mbss_pkg;

	// Fixed widths of the pattern and the configuration port.
	localparam int PAT_BYTES  = 16;
	localparam int LEN_W      = 5;
	localparam int OUT_OFF_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CARE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKWARD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HAVE_PREV = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PREV_OFF  = 3'd6;

	// Search settings shared by the front and back parts.
	typedef struct packed {
		logic [63:0]           pat_lo;
		logic [63:0]           pat_hi;
		logic [PAT_BYTES-1:0]  care;
		logic [LEN_W-1:0]      len;
		logic                  backward;
		logic                  have_prev;
		logic [OUT_OFF_W-1:0]  prev_off;
	} srch_cfg_t;

	// A pattern length is usable when it is nonzero and fits the window.
	function automatic logic len_usable(input logic [LEN_W-1:0] len, input int pmax);
		return (len != '0) && (int'(len) <= pmax);
	endfunction

endpackage

@@ rtl/mbss_front.sv @@
`timescale 1ns / 1ps

module mbss_front import mbss_pkg::*; #(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srch_cfg_t              cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             image_byte,
	input  logic                   last_byte,
	output logic                   rec_valid,
	input  logic                   rec_ready,
	output logic                   rec_hit,
	output logic                   rec_last,
	output logic [OFFSET_BITS-1:0] rec_start,
	output logic [OFFSET_BITS-1:0] rec_seen
);

	logic [7:0]             window_q [PATTERN_MAX];
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   valid_s1;
	logic                   last_s1;
	logic                   counted_s1;

	logic                   advance;
	logic                   accept;
	logic                   flush;
	logic [OFFSET_BITS-1:0] seen_base;
	logic [7:0]             pat_b [PAT_BYTES];
	logic [PATTERN_MAX-1:0] lane_ok;
	logic                   win_ok;
	logic                   len_ok;
	logic [OFFSET_BITS-1:0] len_ext;

	// The stage moves on when it is empty or its record goes into the queue.
	assign advance  = !valid_s1 || rec_ready;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;
	// The final byte's record leaving the stage ends the image.
	assign flush    = valid_s1 && last_s1 && rec_ready;
	assign seen_base = flush ? '0 : seen_q;

	// Shift window: entry k holds the byte k places before the newest one.
	always_ff @(posedge clk) begin
		if (accept) begin
			window_q[0] <= image_byte;
			for (int k = 1; k < PATTERN_MAX; k++) begin
				window_q[k] <= window_q[k-1];
			end
		end
	end

	// Byte count, saturating at all ones, and the stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			counted_s1 <= 1'b0;
		end else begin
			if (accept) begin
				seen_q     <= (&seen_base) ? seen_base : seen_base + 1'b1;
				counted_s1 <= !(&seen_base);
				last_s1    <= last_byte;
			end else if (flush) begin
				seen_q <= '0;
			end
			if (advance) begin
				valid_s1 <= accept;
			end
		end
	end

	// Split the pattern registers into bytes.
	always_comb begin
		for (int b = 0; b < PAT_BYTES; b++) begin
			pat_b[b] = (b < 8) ? cfg.pat_lo[8*(b%8) +: 8] : cfg.pat_hi[8*(b%8) +: 8];
		end
	end

	// Window entry k lines up with pattern byte len-1-k; each lane compares in parallel.
	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			int  i;
			logic care_k;
			i      = int'(cfg.len) - 1 - k;
			care_k = (i >= 0) && (i < PAT_BYTES) && cfg.care[i[3:0]];
			lane_ok[k] = !care_k || (window_q[k] == pat_b[i[3:0]]);
		end
	end

	assign win_ok  = &lane_ok;
	assign len_ok  = len_usable(cfg.len, PATTERN_MAX);
	assign len_ext = OFFSET_BITS'(cfg.len);

	// Record of the newest byte for the back part.
	assign rec_valid = valid_s1;
	assign rec_last  = last_s1;
	assign rec_hit   = counted_s1 && len_ok && (seen_q >= len_ext) && win_ok;
	assign rec_start = seen_q - len_ext;
	assign rec_seen  = seen_q;

`ifndef NO_ASSERTIONS
	// An accepted byte always lands in the compare stage.
	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted byte did not reach the compare stage");
`endif

endmodule

@@ rtl/mbss_queue.sv @@
`timescale 1ns / 1ps

module mbss_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q < (PW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// Occupancy never exceeds the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(DEPTH))
		else $error("queue overflow");
	// A lone push grows the occupancy by exactly one.
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule

@@ rtl/mbss_back.sv @@
`timescale 1ns / 1ps

module mbss_back import mbss_pkg::*; #(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srch_cfg_t              cfg,
	input  logic                   rec_valid,
	output logic                   rec_ready,
	input  logic                   rec_hit,
	input  logic                   rec_last,
	input  logic [OFFSET_BITS-1:0] rec_start,
	input  logic [OFFSET_BITS-1:0] rec_seen,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [OUT_OFF_W-1:0]   match_offset
);

	// Compare width covers both the offset counter and the 32-bit previous offset.
	localparam int CW = ((OFFSET_BITS > OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W) + 1;

	logic                   held_q;
	logic [OFFSET_BITS-1:0] held_off_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic [OUT_OFF_W-1:0]   offset_q;

	logic                   pop;
	logic [CW-1:0]          p_c;
	logic [CW-1:0]          prev_c;
	logic [CW-1:0]          len_c;
	logic [CW-1:0]          seen_c;
	logic                   fwd_ok;
	logic                   bwd_ok;
	logic                   take;
	logic                   next_held;
	logic [OFFSET_BITS-1:0] next_off;
	logic                   final_found;

	assign rec_ready = !out_valid_q || out_ready;
	assign pop       = rec_valid && rec_ready;

	assign p_c    = CW'(rec_start);
	assign prev_c = CW'(cfg.prev_off);
	assign len_c  = CW'(cfg.len);
	assign seen_c = CW'(rec_seen);

	// Candidate selection: forward keeps the first, backward the latest.
	assign fwd_ok = !cfg.have_prev || (p_c > prev_c);
	assign bwd_ok = (p_c >= len_c) && (!cfg.have_prev || (p_c < prev_c));
	assign take   = rec_hit && (cfg.backward ? bwd_ok : (fwd_ok && !held_q));
	assign next_held = held_q || take;
	assign next_off  = take ? rec_start : held_off_q;

	// Qualification of the held match at the end of the image.
	always_comb begin
		final_found = next_held && len_usable(cfg.len, PATTERN_MAX);
		if (cfg.have_prev) begin
			if (!cfg.backward) begin
				if ((prev_c + len_c) > seen_c) begin
					final_found = 1'b0;
				end
			end else begin
				if ((prev_c < len_c) || (prev_c > seen_c)) begin
					final_found = 1'b0;
				end
			end
		end
	end

	// Held match and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && rec_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (rec_last) begin
					held_q <= 1'b0;
				end else begin
					held_q <= next_held;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			held_off_q <= next_off;
			if (rec_last) begin
				found_q  <= final_found;
				offset_q <= final_found ? OUT_OFF_W'(next_off) : '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

`ifndef NO_ASSERTIONS
	// The final byte's record always produces a result.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_ready && rec_last) |=> out_valid_q)
		else $error("final record produced no result");
	// A reported match needs a nonzero pattern length.
	a_found_needs_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_q) |-> (cfg.len != '0))
		else $error("match reported with zero pattern length");
`endif

endmodule

@@ rtl/masked_byte_signature_search.sv @@
`timescale 1ns / 1ps

// Masked byte signature search. Image bytes stream in on the input channel,
// lowest address first, with last_byte set on the final byte; one result
// (found, match_offset) comes out per image. The block takes one byte per cycle
// unless out_ready stalls it: every window position is compared against the
// configured pattern in a single parallel pass, so that comparator stage sets
// the rate. A front part shifts the window, counts bytes and flags candidate
// matches; a two-entry queue carries those records to a back part that keeps
// the first (forward) or latest (backward) qualifying match and registers the
// result. out_valid rises once the final byte's record reaches the result
// register. Configuration registers are written through the cfg channel,
// which is always ready, and must be changed only while no image is in flight.
module masked_byte_signature_search import mbss_pkg::*; #(
	parameter int PATTERN_MAX = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            image_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  found,
	output logic [OUT_OFF_W-1:0]  match_offset
);

	localparam int RW = 2 + 2 * OFFSET_BITS;

	srch_cfg_t              cfg_q;
	logic                   f_valid;
	logic                   f_ready;
	logic                   f_hit;
	logic                   f_last;
	logic [OFFSET_BITS-1:0] f_start;
	logic [OFFSET_BITS-1:0] f_seen;
	logic [RW-1:0]          q_push_data;
	logic [RW-1:0]          q_pop_data;
	logic                   b_valid;
	logic                   b_ready;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAT_LO:    cfg_q.pat_lo    <= cfg_data;
				CFG_PAT_HI:    cfg_q.pat_hi    <= cfg_data;
				CFG_CARE:      cfg_q.care      <= cfg_data[PAT_BYTES-1:0];
				CFG_LEN:       cfg_q.len       <= cfg_data[LEN_W-1:0];
				CFG_BACKWARD:  cfg_q.backward  <= cfg_data[0];
				CFG_HAVE_PREV: cfg_q.have_prev <= cfg_data[0];
				CFG_PREV_OFF:  cfg_q.prev_off  <= cfg_data[OUT_OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Front part: window, byte count and pattern compare.
	mbss_front #(
		.PATTERN_MAX (PATTERN_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.image_byte (image_byte),
		.last_byte  (last_byte),
		.rec_valid  (f_valid),
		.rec_ready  (f_ready),
		.rec_hit    (f_hit),
		.rec_last   (f_last),
		.rec_start  (f_start),
		.rec_seen   (f_seen)
	);

	assign q_push_data = {f_hit, f_last, f_start, f_seen};

	// Queue between the two parts.
	mbss_queue #(
		.WIDTH (RW),
		.DEPTH (2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_push_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_pop_data)
	);

	// Back part: match selection and result register.
	mbss_back #(
		.PATTERN_MAX (PATTERN_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.rec_valid    (b_valid),
		.rec_ready    (b_ready),
		.rec_hit      (q_pop_data[RW-1]),
		.rec_last     (q_pop_data[RW-2]),
		.rec_start    (q_pop_data[2*OFFSET_BITS-1:OFFSET_BITS]),
		.rec_seen     (q_pop_data[OFFSET_BITS-1:0]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset)
	);

endmodule
